// ----- design/assert_macros.svh -----
// Assertion macros used by the ticket queue unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TQU_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("%m: invariant violated");

// Checks that a consequent holds in the cycle after its antecedent.
`define TQU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- design/tqu_pkg.sv -----
// Types and constants for the ticket queue with undo history.
package tqu_pkg;

    localparam int QUEUE_DEPTH_DEF   = 128;
    localparam int HISTORY_DEPTH_DEF = 128;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 88;
    localparam int LEVEL_W     = 8;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_CALL    = 2'd1,
        CMD_CANCEL  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STATUS_OK            = 3'd0,
        STATUS_QUEUE_FULL    = 3'd1,
        STATUS_QUEUE_EMPTY   = 3'd2,
        STATUS_HISTORY_EMPTY = 3'd3,
        STATUS_CANCEL_KEPT   = 3'd4,
        STATUS_DROPPED       = 3'd5
    } status_t;

    typedef struct packed {
        logic [15:0] passenger;
        logic [15:0] train;
        logic [23:0] fare;
        logic [15:0] ticket;
    } ticket_t;

endpackage

// ----- design/ticket_queue_with_undo_stack_unit.sv -----
// Ticket queue on a ring buffer with a call history stack that can be undone.
//
// Channel | Dir | tdata (low bit up)                                 | tuser
// s_axis  | in  | passenger_id, train_no, fare, ticket_no             | cmd
// m_axis  | out | out_passenger, out_train, out_fare, out_ticket,     | status
//         |     | queue_level, history_level                          |
//
// A command passes from the input register to the result register. One beat is taken
// every cycle unless a stall on the result side holds the input register and then the
// input channel. The queue head and the history top are prefetched from their memories
// into read registers, with the same-cycle write forwarded, so the next command finds
// them ready. Reset clears the counters and head pointer; the memories are not cleared.
`include "assert_macros.svh"

module ticket_queue_with_undo_stack_unit #(
    parameter int QUEUE_DEPTH   = tqu_pkg::QUEUE_DEPTH_DEF,
    parameter int HISTORY_DEPTH = tqu_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // passenger_id, train_no, fare, ticket_no
    input  logic [tqu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_passenger, out_train, out_fare, out_ticket, queue_level, history_level
    output logic [tqu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [2:0]                      m_axis_tuser
);
    import tqu_pkg::*;

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int HA_W = $clog2(HISTORY_DEPTH);
    localparam int HC_W = $clog2(HISTORY_DEPTH + 1);

    ticket_t q_mem [QUEUE_DEPTH];
    ticket_t h_mem [HISTORY_DEPTH];

    logic            in_valid_reg;
    cmd_t            in_cmd_reg;
    ticket_t         in_tk_reg;

    logic            out_valid_reg;
    status_t         out_status_reg;
    ticket_t         out_tk_reg;
    logic [LEVEL_W-1:0] out_qlvl_reg;
    logic [LEVEL_W-1:0] out_hlvl_reg;

    logic [QA_W-1:0] q_head_reg, q_head_next;
    logic [QC_W-1:0] q_count_reg, q_count_next;
    logic [HC_W-1:0] h_count_reg, h_count_next;
    ticket_t         q_rd_reg;
    ticket_t         h_rd_reg;

    logic            proc;
    logic            call_pop;
    logic            q_full, h_full;
    logic [QC_W:0]   tail_sum, tail_wrap;
    logic [QA_W-1:0] head_inc, head_dec;
    logic [HC_W-1:0] h_top_idx;
    logic [QA_W-1:0] q_raddr;
    logic [HA_W-1:0] h_raddr;

    logic            q_we, h_we;
    logic [QA_W-1:0] q_waddr;
    logic [HA_W-1:0] h_waddr;
    ticket_t         q_wdata, h_wdata;
    status_t         status;
    ticket_t         res_tk;

    assign proc          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg          <= cmd_t'(s_axis_tuser);
            in_tk_reg.passenger <= s_axis_tdata[15:0];
            in_tk_reg.train     <= s_axis_tdata[31:16];
            in_tk_reg.fare      <= s_axis_tdata[55:32];
            in_tk_reg.ticket    <= s_axis_tdata[71:56];
        end
    end

    assign q_full    = (q_count_reg == QC_W'(QUEUE_DEPTH));
    assign h_full    = (h_count_reg == HC_W'(HISTORY_DEPTH));
    assign tail_sum  = (QC_W + 1)'(q_head_reg) + (QC_W + 1)'(q_count_reg);
    assign tail_wrap = (tail_sum >= (QC_W + 1)'(QUEUE_DEPTH)) ?
                       tail_sum - (QC_W + 1)'(QUEUE_DEPTH) : tail_sum;
    assign head_inc  = (q_head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_reg + 1'b1;
    assign head_dec  = (q_head_reg == '0) ? QA_W'(QUEUE_DEPTH - 1) : q_head_reg - 1'b1;

    always_comb begin
        q_head_next  = q_head_reg;
        q_count_next = q_count_reg;
        h_count_next = h_count_reg;
        q_we         = 1'b0;
        q_waddr      = tail_wrap[QA_W-1:0];
        q_wdata      = in_tk_reg;
        h_we         = 1'b0;
        h_waddr      = h_count_reg[HA_W-1:0];
        h_wdata      = q_rd_reg;
        status       = STATUS_OK;
        res_tk       = '0;
        if (proc) begin
            case (in_cmd_reg)
                CMD_ENQUEUE: begin
                    if (q_full) begin
                        status = STATUS_QUEUE_FULL;
                    end else begin
                        q_we         = 1'b1;
                        q_count_next = q_count_reg + 1'b1;
                    end
                end
                CMD_CALL: begin
                    if (q_count_reg == '0) begin
                        status = STATUS_QUEUE_EMPTY;
                    end else begin
                        res_tk       = q_rd_reg;
                        q_head_next  = head_inc;
                        q_count_next = q_count_reg - 1'b1;
                        if (h_full) begin
                            status = STATUS_DROPPED;
                        end else begin
                            h_we         = 1'b1;
                            h_count_next = h_count_reg + 1'b1;
                        end
                    end
                end
                CMD_CANCEL: begin
                    if (h_count_reg == '0) begin
                        status = STATUS_HISTORY_EMPTY;
                    end else begin
                        res_tk = h_rd_reg;
                        if (q_full) begin
                            status = STATUS_CANCEL_KEPT;
                        end else begin
                            h_count_next = h_count_reg - 1'b1;
                            q_head_next  = head_dec;
                            q_count_next = q_count_reg + 1'b1;
                            q_we         = 1'b1;
                            q_waddr      = head_dec;
                            q_wdata      = h_rd_reg;
                        end
                    end
                end
                default: begin
                    status = STATUS_OK;
                end
            endcase
        end
    end

    assign q_raddr   = q_head_next;
    assign h_top_idx = h_count_next - 1'b1;
    assign h_raddr   = h_top_idx[HA_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_head_reg  <= '0;
            q_count_reg <= '0;
            h_count_reg <= '0;
        end else begin
            q_head_reg  <= q_head_next;
            q_count_reg <= q_count_next;
            h_count_reg <= h_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (q_we && (q_waddr == q_raddr)) begin
            q_rd_reg <= q_wdata;
        end else begin
            q_rd_reg <= q_mem[q_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (h_we) begin
            h_mem[h_waddr] <= h_wdata;
        end
        if (h_we && (h_waddr == h_raddr)) begin
            h_rd_reg <= h_wdata;
        end else begin
            h_rd_reg <= h_mem[h_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_status_reg <= status;
            out_tk_reg     <= res_tk;
            out_qlvl_reg   <= LEVEL_W'(q_count_next);
            out_hlvl_reg   <= LEVEL_W'(h_count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_hlvl_reg, out_qlvl_reg, out_tk_reg.ticket, out_tk_reg.fare,
                            out_tk_reg.train, out_tk_reg.passenger};

    assign call_pop = proc && (in_cmd_reg == CMD_CALL) && (q_count_reg != '0);

    `TQU_ASSERT_ALWAYS(a_queue_bound, aclk, aresetn, q_count_reg <= QC_W'(QUEUE_DEPTH))
    `TQU_ASSERT_ALWAYS(a_history_bound, aclk, aresetn, h_count_reg <= HC_W'(HISTORY_DEPTH))
    `TQU_ASSERT_NEXT(a_call_pops, aclk, aresetn, call_pop, q_count_reg == $past(q_count_reg) - 1'b1)
    `TQU_ASSERT_NEXT(a_result_follows, aclk, aresetn, proc, m_axis_tvalid)

endmodule
